// File: src/lrs48_pkg.sv
// Shared constants and controller/datapath interface types for the 48 kHz resampler.
package lrs48_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 16;
    localparam int FRAC_W      = 32;
    localparam int STEP_W      = 33;
    localparam int POS_W       = 34;
    localparam int CNT_W       = 3;
    localparam int DIV_CNT_W   = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_PROD_W = 48;
    localparam int STEP_FRAC_W = 15;

    localparam logic [CNT_W-1:0]     MAX_OUT     = 3'd6;
    localparam logic [RATE_W-1:0]    TARGET_RATE = 16'd48000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 1'd1;
    localparam logic [STEP_W-1:0]    STEP_RESET  = 33'h1_0000_0000;

    // step = rate * 2^32 / 48000 = rate * 89478 + floor(rate * 182 / 375);
    // the second term is rate * 182 * ceil(2^33 / 375) >> 33
    localparam logic [STEP_W-1:0]      STEP_INT_K  = 33'd89478;
    localparam logic [STEP_PROD_W-1:0] STEP_FRAC_K = 48'd4168981726;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 2'd1;

    typedef struct packed {
        logic load_cur;
        logic store_first;
        logic clear_interp;
        logic start_run;
        logic mul;
        logic emit;
        logic finish;
        logic pass_emit;
        logic div_step;
    } lrs48_cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic pass_mode;
        logic primed;
        logic pos_below_one;
        logic run_full;
        logic out_free;
        logic div_last;
        logic cfg_start;
    } lrs48_sts_t;

endpackage

// File: src/lrs48_ctrl.sv
// Sequencer: per-request decisions, output loop and step-division timing.
module lrs48_ctrl
    import lrs48_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lrs48_sts_t sts,
    output lrs48_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_OUT,
        S_PASS
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_cur = 1'b1;
                    if (sts.rate_zero) begin
                        state_next = S_IDLE;
                    end else if (sts.pass_mode) begin
                        cmd.clear_interp = 1'b1;
                        state_next       = S_PASS;
                    end else if (!sts.primed) begin
                        cmd.store_first = 1'b1;
                    end else begin
                        cmd.start_run = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_IDLE;
                end
            end
            S_MUL: begin
                if (sts.pos_below_one && !sts.run_full) begin
                    cmd.mul    = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_PASS: begin
                if (sts.out_free) begin
                    cmd.pass_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (sts.cfg_start) begin
            cmd.div_step = 1'b0;
            state_next   = S_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_accept_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> !s_tready)
        else $error("request accepted during step division");
    a_run_enters_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_run && !sts.cfg_start |=> state_reg == S_MUL)
        else $error("run start did not enter the output loop");
    a_emit_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit || cmd.pass_emit |-> sts.out_free)
        else $error("output loaded while occupied");

endmodule

// File: src/lrs48_dp.sv
// Datapath: config registers, phase-step logic, position, blend multipliers, output register.
module lrs48_dp
    import lrs48_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_wdata,
    input  logic [31:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast,
    input  lrs48_cmd_t           cmd,
    output lrs48_sts_t           sts
);

    logic [RATE_W-1:0]          source_rate_reg;
    logic                       mono_reg;
    logic [STEP_W-1:0]          rate_step_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic [STEP_W-1:0]          step_int_reg;
    logic [STEP_FRAC_W-1:0]     step_frac_reg;
    logic signed [SAMPLE_W-1:0] cur_l_reg, cur_r_reg;
    logic signed [SAMPLE_W-1:0] prev_l_reg, prev_r_reg;
    logic                       primed_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [CNT_W-1:0]           run_cnt_reg;
    logic signed [17:0]         prod_l_reg, prod_r_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;
    logic                       m_tlast_reg;

    logic                       cfg_rate_wr, cfg_mono_wr, cfg_clear;
    logic [STEP_W-1:0]          step_int_prod;
    logic [STEP_PROD_W-1:0]     step_frac_prod;
    logic signed [SAMPLE_W-1:0] in_l, in_r;
    logic signed [16:0]         diff_l, diff_r;
    logic signed [49:0]         prod_l, prod_r;
    logic signed [17:0]         sum_l, sum_r;
    logic [SAMPLE_W-1:0]        sat_l, sat_r;
    logic [POS_W-1:0]           pos_adv, pos_wrap;

    function automatic logic [SAMPLE_W-1:0] clamp16(input logic signed [17:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    assign cfg_rate_wr = cfg_we && (cfg_index == REG_SOURCE_RATE);
    assign cfg_mono_wr = cfg_we && (cfg_index == REG_MONO_SOURCE);
    assign cfg_clear   = cfg_rate_wr || cfg_mono_wr;

    // Phase step: constant multiplies registered first, summed on the last step cycle.
    assign step_int_prod  = {{(STEP_W-RATE_W){1'b0}}, source_rate_reg} * STEP_INT_K;
    assign step_frac_prod = {{(STEP_PROD_W-RATE_W){1'b0}}, source_rate_reg} * STEP_FRAC_K;

    assign in_l = s_tdata[15:0];
    assign in_r = mono_reg ? s_tdata[15:0] : s_tdata[31:16];

    assign diff_l = {cur_l_reg[15], cur_l_reg} - {prev_l_reg[15], prev_l_reg};
    assign diff_r = {cur_r_reg[15], cur_r_reg} - {prev_r_reg[15], prev_r_reg};
    assign prod_l = diff_l * $signed({1'b0, pos_reg[FRAC_W-1:0]});
    assign prod_r = diff_r * $signed({1'b0, pos_reg[FRAC_W-1:0]});

    assign sum_l = {{2{prev_l_reg[15]}}, prev_l_reg} + prod_l_reg;
    assign sum_r = {{2{prev_r_reg[15]}}, prev_r_reg} + prod_r_reg;
    assign sat_l = clamp16(sum_l);
    assign sat_r = clamp16(sum_r);

    assign pos_adv  = pos_reg + {1'b0, rate_step_reg};
    assign pos_wrap = (pos_reg[POS_W-1:FRAC_W] != 2'b00)
                    ? pos_reg - {2'b01, {FRAC_W{1'b0}}} : pos_reg;

    assign sts.rate_zero     = (source_rate_reg == '0);
    assign sts.pass_mode     = (source_rate_reg == TARGET_RATE) && !mono_reg;
    assign sts.primed        = primed_reg;
    assign sts.pos_below_one = (pos_reg[POS_W-1:FRAC_W] == 2'b00);
    assign sts.run_full      = (run_cnt_reg == MAX_OUT);
    assign sts.out_free      = !m_tvalid_reg || m_tready;
    assign sts.div_last      = (div_cnt_reg == '0);
    assign sts.cfg_start     = cfg_rate_wr;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_rate_reg <= TARGET_RATE;
            mono_reg        <= 1'b0;
            rate_step_reg   <= STEP_RESET;
            div_cnt_reg     <= '0;
            prev_l_reg      <= '0;
            prev_r_reg      <= '0;
            primed_reg      <= 1'b0;
            pos_reg         <= '0;
            run_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_rate_wr) begin
                source_rate_reg <= cfg_wdata;
                div_cnt_reg     <= DIV_LAST;
            end else if (cmd.div_step) begin
                if (sts.div_last) begin
                    rate_step_reg <= step_int_reg
                                   + {{(STEP_W-STEP_FRAC_W){1'b0}}, step_frac_reg};
                end else begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
            end
            if (cfg_mono_wr) begin
                mono_reg <= cfg_wdata[0];
            end

            if (cfg_clear || cmd.clear_interp) begin
                prev_l_reg <= '0;
                prev_r_reg <= '0;
                primed_reg <= 1'b0;
                pos_reg    <= '0;
            end else if (cmd.store_first) begin
                prev_l_reg <= in_l;
                prev_r_reg <= in_r;
                primed_reg <= 1'b1;
            end else if (cmd.emit) begin
                pos_reg <= pos_adv;
            end else if (cmd.finish) begin
                pos_reg    <= pos_wrap;
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
            end

            if (cmd.start_run) begin
                run_cnt_reg <= '0;
            end else if (cmd.emit) begin
                run_cnt_reg <= run_cnt_reg + 1'b1;
            end

            if (cmd.emit || cmd.pass_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            step_int_reg  <= step_int_prod;
            step_frac_reg <= step_frac_prod[STEP_PROD_W-1:STEP_PROD_W-STEP_FRAC_W];
        end
        if (cmd.load_cur) begin
            cur_l_reg <= in_l;
            cur_r_reg <= in_r;
        end
        if (cmd.mul) begin
            prod_l_reg <= prod_l[49:32];
            prod_r_reg <= prod_r[49:32];
        end
        if (cmd.emit) begin
            m_tdata_reg <= {sat_r, sat_l};
            m_tlast_reg <= (pos_adv[POS_W-1:FRAC_W] != 2'b00)
                        || (run_cnt_reg == MAX_OUT - 1'b1);
        end else if (cmd.pass_emit) begin
            m_tdata_reg <= {cur_r_reg, cur_l_reg};
            m_tlast_reg <= 1'b1;
        end
    end

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_cnt_reg <= MAX_OUT)
        else $error("output count past limit");
    a_last_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && run_cnt_reg == MAX_OUT - 1'b1 |=> m_tvalid_reg && m_tlast_reg)
        else $error("final pair of a full run not marked last");
    a_pass_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_emit |=> m_tlast_reg && !primed_reg)
        else $error("passthrough left interpolation state");

endmodule

// File: src/linear_resampler_to_48k_stereo_top.sv
// Top level of the linear-interpolation resampler to 48 kHz stereo.
// Each accepted request is one source sample pair; the block returns every 48 kHz pair whose
// position falls between the previous and the current source sample, at most six per request,
// the last one flagged by m_tlast. Each output pair takes a 17x33 multiply per channel, then
// the add and clamp into the output register, which waits while that register is occupied;
// a closing step then ends the run. A 48 kHz stereo source passes straight through;
// otherwise the first sample after reset or a write only primes the interpolator. Writing
// source_rate starts a phase-step computation (constant multiplies, then an add), during
// which s_tready stays low. The output register lets the next request in while a pair
// still waits on m_tready.
module linear_resampler_to_48k_stereo_top
    import lrs48_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [15:0] out_left, [31:16] out_right
    output logic                 m_tlast    // last_of_run
);

    lrs48_cmd_t cmd;
    lrs48_sts_t sts;

    lrs48_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrs48_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: tb/sv/linear_resampler_to_48k_stereo_top_tb.sv
// Self-checking testbench for the 48 kHz stereo linear-interpolation resampler.
`timescale 1ns / 1ps

module linear_resampler_to_48k_stereo_top_tb;
    import lrs48_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PAIRS = 220;
    localparam logic [POS_W-1:0] ONE_POS = 34'h1_0000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'h7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'h8000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic                       last_of_run;
        logic signed [SAMPLE_W-1:0] out_right;
        logic signed [SAMPLE_W-1:0] out_left;
    } pair_t;

    typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

    typedef struct {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [RATE_W-1:0]          val;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        chk_t                       chk;
        logic signed [SAMPLE_W-1:0] el;
        logic signed [SAMPLE_W-1:0] er;
    } row_t;

    localparam int PLAN_LEN = 36;

    row_t plan [PLAN_LEN] = '{
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_ONE,   S_MAX,  S_MIN},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  S_MAX,  CHK_ONE,   S_MIN,  S_MAX},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd0, 16'sd0, CHK_ONE,   16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     -16'sd1, 16'sd1, CHK_ONE,  -16'sd1, 16'sd1},
        '{ROW_WRITE, REG_MONO_SOURCE, 16'd1,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd100, 16'sd5, CHK_NONE, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  16'sd7, CHK_ONE,   16'sd100, 16'sd100},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_ONE,   S_MIN,  S_MIN},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd0, S_MAX,  CHK_ONE,   S_MAX,  S_MAX},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd0,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd1234, -16'sd1234, CHK_NONE, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     -16'sd1, -16'sd1, CHK_NONE, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd8000,  16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_MONO_SOURCE, 16'd0,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_NONE,  16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  S_MAX,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd65535, 16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  S_MIN,  CHK_NONE,  16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MAX,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd0, S_MAX,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd12345, -16'sd12345, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd1,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_NONE,  16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  S_MAX,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SPARE_2,     16'hFFFF,  16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SPARE_3,     16'h0000,  16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd44100, 16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_MONO_SOURCE, 16'hFFFE,  16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MIN,  S_MAX,  CHK_NONE,  16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     S_MAX,  S_MIN,  CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_PAIR,  REG_SOURCE_RATE, 16'd0,     -16'sd2, 16'sd2, CHK_MODEL, 16'sd0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_RATE, 16'd48000, 16'sd0, 16'sd0, CHK_MODEL, 16'sd0, 16'sd0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RATE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;   // [15:0] left_sample, [31:16] right_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // [15:0] out_left, [31:16] out_right
    logic                 m_tlast;        // last_of_run

    linear_resampler_to_48k_stereo_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // interpolator shadow state
    logic [RATE_W-1:0]          rate_q;
    logic                       mono_q;
    logic signed [SAMPLE_W-1:0] hist_l;
    logic signed [SAMPLE_W-1:0] hist_r;
    logic                       primed;
    logic [FRAC_W-1:0]          phase_frac;
    logic                       phase_ahead;
    logic [STEP_W-1:0]          phase_step;

    pair_t burst [6];
    pair_t pending_pairs [$];
    chk_t  typed_mode = CHK_MODEL;
    pair_t typed_pair = '0;

    int send_idle_pct = 30;
    int recv_idle_pct = 54;
    int cycle_cnt = 0;
    int mismatches = 0;
    int pairs_in = 0;
    int pairs_ignored = 0;
    int pairs_out = 0;
    int reg_writes = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs still pending",
                     cycle_cnt, pending_pairs.size());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic logic signed [SAMPLE_W-1:0] blend16(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRAC_W-1:0] frac
    );
        longint w1;
        longint acc;
        longint q;
        w1 = longint'({32'b0, frac});
        acc = longint'(a) * (64'sh1_0000_0000 - w1) + longint'(b) * w1;
        q = acc >>> 32;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic void restart_interp();
        logic [63:0] scaled;
        scaled = {16'b0, rate_q, 32'b0};
        hist_l = '0;
        hist_r = '0;
        primed = 1'b0;
        phase_frac = '0;
        phase_ahead = 1'b0;
        phase_step = STEP_W'(scaled / 64'(TARGET_RATE));
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [RATE_W-1:0] val);
        case (idx)
            REG_SOURCE_RATE: rate_q = val;
            REG_MONO_SOURCE: mono_q = val[0];
            default: return;
        endcase
        restart_interp();
    endfunction

    // fills burst[] with the pairs one source pair releases, returns the count
    function automatic int interpolate_pairs(input logic signed [SAMPLE_W-1:0] in_l,
                                             input logic signed [SAMPLE_W-1:0] in_r);
        logic signed [SAMPLE_W-1:0] cur_l;
        logic signed [SAMPLE_W-1:0] cur_r;
        logic [POS_W-1:0]           pos;
        int                         n;
        cur_l = in_l;
        cur_r = mono_q ? in_l : in_r;
        n = 0;
        if (rate_q == '0) return 0;
        if (rate_q == TARGET_RATE && !mono_q) begin
            burst[0] = '{last_of_run: 1'b1, out_right: cur_r, out_left: cur_l};
            restart_interp();
            return 1;
        end
        if (!primed) begin
            hist_l = cur_l;
            hist_r = cur_r;
            primed = 1'b1;
            return 0;
        end
        pos = {1'b0, phase_ahead, phase_frac};
        while (pos < ONE_POS && n < int'(MAX_OUT)) begin
            burst[n] = '{last_of_run: 1'b0,
                         out_right: blend16(hist_r, cur_r, pos[FRAC_W-1:0]),
                         out_left: blend16(hist_l, cur_l, pos[FRAC_W-1:0])};
            n++;
            pos = pos + POS_W'(phase_step);
        end
        if (n > 0) burst[n-1].last_of_run = 1'b1;
        if (pos >= ONE_POS) pos = pos - ONE_POS;
        phase_ahead = (pos >= ONE_POS);
        phase_frac = pos[FRAC_W-1:0];
        hist_l = cur_l;
        hist_r = cur_r;
        return n;
    endfunction

    function automatic void log_mismatch(input logic has_want, input pair_t want,
                                         input pair_t got);
        mismatches++;
        if (mismatches <= 10) begin
            if (has_want)
                $display("%0t: mismatch, expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                         $time, want.out_left, want.out_right, want.last_of_run,
                         got.out_left, got.out_right, got.last_of_run);
            else
                $display("%0t: output with nothing pending, got L=%0d R=%0d last=%0b",
                         $time, got.out_left, got.out_right, got.last_of_run);
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        pair_t got;
        pair_t want;
        int    n;
        if (!aresetn) begin
            rate_q = TARGET_RATE;
            mono_q = 1'b0;
            restart_interp();
            pending_pairs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{last_of_run: m_tlast, out_right: m_tdata[31:16],
                        out_left: m_tdata[15:0]};
                pairs_out++;
                if (pending_pairs.size() == 0) begin
                    log_mismatch(1'b0, got, got);
                end else begin
                    want = pending_pairs.pop_front();
                    if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
                        got.last_of_run !== want.last_of_run)
                        log_mismatch(1'b1, want, got);
                end
            end
            if (cfg_we) begin
                set_reg(cfg_index, cfg_wdata);
                reg_writes++;
            end
            if (s_tvalid && s_tready) begin
                if (rate_q == '0) pairs_ignored++;
                else pairs_in++;
                n = interpolate_pairs(s_tdata[15:0], s_tdata[31:16]);
                case (typed_mode)
                    CHK_MODEL: for (int i = 0; i < n; i++) pending_pairs.push_back(burst[i]);
                    CHK_ONE: pending_pairs.push_back(typed_pair);
                    default: ;
                endcase
            end
        end
    end

    task automatic send_pair(input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] edge_sample();
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin
        logic [RATE_W-1:0] rate_pick;
        logic [31:0]       word;
        int                n_rand;
        int                seg_len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                program_reg(plan[i].idx, plan[i].val);
            end else begin
                typed_mode <= plan[i].chk;
                typed_pair <= '{last_of_run: 1'b1, out_right: plan[i].er, out_left: plan[i].el};
                send_pair({plan[i].r, plan[i].l});
            end
        end

        typed_mode <= CHK_MODEL;
        n_rand = 0;
        while (n_rand < RANDOM_PAIRS) begin
            case ($urandom_range(0, 9))
                0: rate_pick = 16'd8000;
                1: rate_pick = 16'd48000;
                2: rate_pick = 16'd44100;
                3: rate_pick = 16'd22050;
                4: rate_pick = 16'd16000;
                5: rate_pick = 16'd32000;
                6: rate_pick = RATE_W'($urandom_range(8000, 48000));
                7: rate_pick = RATE_W'($urandom_range(48001, 65535));
                8: rate_pick = RATE_W'($urandom_range(1, 7999));
                default: rate_pick = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd11025;
            endcase
            program_reg(REG_SOURCE_RATE, rate_pick);
            program_reg(REG_MONO_SOURCE, RATE_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 7) == 0)
                program_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                            RATE_W'($urandom_range(0, 65535)));
            seg_len = (rate_pick == '0) ? $urandom_range(3, 6) : $urandom_range(8, 30);
            for (int k = 0; k < seg_len; k++) begin
                if (n_rand >= 2 * RANDOM_PAIRS / 3) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end else if (n_rand >= RANDOM_PAIRS / 3) begin
                    send_idle_pct = 54;
                    recv_idle_pct = 30;
                end
                // hold off until the output side has caught up
                if ($urandom_range(0, 19) == 0 && pending_pairs.size() != 0) begin
                    s_tvalid <= 1'b0;
                    while (pending_pairs.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(0, 7) == 0) word = {edge_sample(), edge_sample()};
                else word = $urandom();
                send_pair(word);
                if (rate_pick != '0) n_rand++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d source pairs (%0d more while the rate was zero), %0d register writes,",
                 pairs_in, pairs_ignored, reg_writes);
        $display("checked %0d output pairs across rates from 0 to 65535, mono and stereo.",
                 pairs_out);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
src/lrs48_pkg.sv
src/lrs48_ctrl.sv
src/lrs48_dp.sv
src/linear_resampler_to_48k_stereo_top.sv
tb/sv/linear_resampler_to_48k_stereo_top_tb.sv
